### hdl/gemm_aes_pkg.sv
`default_nettype none

package gemm_aes_pkg;

    // Transaction field widths
    localparam int ACTION_W = 2;
    localparam int IDX_W    = 4;
    localparam int VALUE_W  = 16;
    localparam int RES_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int DIMREG_W = 5;

    // Register port
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // Shared multiplier
    localparam int MUL_W    = 18;
    localparam int PROD_W   = 2 * MUL_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_LOAD_C  = 2'd2,
        ACT_COMPUTE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_ROWS_A    = 3'd0,
        REG_COLS_B    = 3'd1,
        REG_INNER_LEN = 3'd2,
        REG_ALPHA     = 3'd3,
        REG_BETA      = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MAC, ST_DRN1, ST_DRN2, ST_MHI, ST_MMID, ST_MLO, ST_MBC,
        ST_SHI, ST_SMID, ST_SLO, ST_SFIN, ST_TRND, ST_SRND, ST_OUT
    } t_step;

    typedef enum logic [2:0] {
        MUL_AB, MUL_AHI, MUL_AMID, MUL_ALO, MUL_BC, MUL_SHI, MUL_SMID, MUL_SLO
    } t_mul_sel;

    typedef enum logic [2:0] {
        OP_NONE, OP_T_LOAD, OP_T_SHADD, OP_T_ADD8, OP_T_RND,
        OP_S_LOAD, OP_S_SHADD, OP_S_RND
    } t_acc_op;

    typedef enum logic [1:0] {
        COND_NONE, COND_K_MORE, COND_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_mul_sel mul;
        t_acc_op  op;
        logic     issue;
        t_cond    cond;
        t_step    jmp;
        t_step    nxt;
    } t_uword;

    function automatic t_uword f_uw(input t_mul_sel mul, input t_acc_op op,
                                    input logic issue, input t_cond cond,
                                    input t_step jmp, input t_step nxt);
        t_uword w;
        w.mul   = mul;
        w.op    = op;
        w.issue = issue;
        w.cond  = cond;
        w.jmp   = jmp;
        w.nxt   = nxt;
        return w;
    endfunction

    // Control store: jump to jmp when the condition holds, else go to nxt
    function automatic t_uword f_ucode(input t_step s);
        t_uword w;
        unique case (s)
            ST_MAC:  w = f_uw(MUL_AB,   OP_NONE,    1'b1, COND_K_MORE,   ST_MAC,  ST_DRN1);
            ST_DRN1: w = f_uw(MUL_AB,   OP_NONE,    1'b0, COND_NONE,     ST_IDLE, ST_DRN2);
            ST_DRN2: w = f_uw(MUL_AB,   OP_NONE,    1'b0, COND_NONE,     ST_IDLE, ST_MHI);
            ST_MHI:  w = f_uw(MUL_AHI,  OP_NONE,    1'b0, COND_NONE,     ST_IDLE, ST_MMID);
            ST_MMID: w = f_uw(MUL_AMID, OP_T_LOAD,  1'b0, COND_NONE,     ST_IDLE, ST_MLO);
            ST_MLO:  w = f_uw(MUL_ALO,  OP_T_SHADD, 1'b0, COND_NONE,     ST_IDLE, ST_MBC);
            ST_MBC:  w = f_uw(MUL_BC,   OP_T_SHADD, 1'b0, COND_NONE,     ST_IDLE, ST_SHI);
            ST_SHI:  w = f_uw(MUL_SHI,  OP_T_ADD8,  1'b0, COND_NONE,     ST_IDLE, ST_SMID);
            ST_SMID: w = f_uw(MUL_SMID, OP_S_LOAD,  1'b0, COND_NONE,     ST_IDLE, ST_SLO);
            ST_SLO:  w = f_uw(MUL_SLO,  OP_S_SHADD, 1'b0, COND_NONE,     ST_IDLE, ST_SFIN);
            ST_SFIN: w = f_uw(MUL_AB,   OP_S_SHADD, 1'b0, COND_NONE,     ST_IDLE, ST_TRND);
            ST_TRND: w = f_uw(MUL_AB,   OP_T_RND,   1'b0, COND_NONE,     ST_IDLE, ST_SRND);
            ST_SRND: w = f_uw(MUL_AB,   OP_S_RND,   1'b0, COND_NONE,     ST_IDLE, ST_OUT);
            ST_OUT:  w = f_uw(MUL_AB,   OP_NONE,    1'b0, COND_OUT_FULL, ST_OUT,  ST_IDLE);
            default: w = f_uw(MUL_AB,   OP_NONE,    1'b0, COND_NONE,     ST_IDLE, ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/gemm_aes_if.sv
`default_nettype none

interface gemm_aes_in_if;
    logic                                       valid;
    logic                                       ready;
    logic        [gemm_aes_pkg::ACTION_W-1:0]   action;
    logic        [gemm_aes_pkg::IDX_W-1:0]      row;
    logic        [gemm_aes_pkg::IDX_W-1:0]      col;
    logic signed [gemm_aes_pkg::VALUE_W-1:0]    value;

    modport source (output valid, action, row, col, value, input ready);
    modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface gemm_aes_out_if;
    logic                                       valid;
    logic                                       ready;
    logic        [gemm_aes_pkg::IDX_W-1:0]      out_row;
    logic        [gemm_aes_pkg::IDX_W-1:0]      out_col;
    logic signed [gemm_aes_pkg::RES_W-1:0]      c_value;
    logic        [gemm_aes_pkg::RES_W-1:0]      scale_value;
    logic                                       saturated;

    modport source (output valid, out_row, out_col, c_value, scale_value, saturated,
                    input ready);
    modport sink   (input valid, out_row, out_col, c_value, scale_value, saturated,
                    output ready);
endinterface

`default_nettype wire

### hdl/gemm_with_abs_error_scale.sv
`default_nettype none

// Element-wise GEMM engine: C = alpha*A*B + beta*C plus the bound |alpha|*sum|a||b|.
// i_item carries one transaction per item: load A, load B, load C (one Q8.8
// element at row/col) or compute the C element at row/col. o_result carries
// one transaction per in-range compute item; loads and out-of-range computes
// give none. The APB port holds rows_a, cols_b, inner_len, alpha_gain and
// beta_gain at byte addresses 0, 4, 8, 12 and 16; write them only while idle.
// A load leaves the sequencer idle. A compute item runs through
// inner_len multiply-accumulate steps, then 13 microcode steps that
// scale, round and saturate, all on one shared 18x18 multiplier sequenced by
// a read-only control store. The result lands in an output register; the
// block takes the next item while that register waits. If the receiver
// stalls with the register still full, the sequencer holds at its last step.
// Reset restores the register defaults and empties the output register; the
// A, B and C stores are not cleared and must be loaded before use.
module gemm_with_abs_error_scale #(
    parameter int MAX_DIM = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    gemm_aes_in_if.sink                           i_item,
    gemm_aes_out_if.source                        o_result,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gemm_aes_pkg::PADDR_W-1:0]      paddr,
    input  logic [gemm_aes_pkg::PDATA_W-1:0]      pwdata,
    output logic [gemm_aes_pkg::PDATA_W-1:0]      prdata,
    output logic                                  pready
);

    localparam int RW      = $clog2(MAX_DIM);
    localparam int DW      = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int MW      = $clog2(DEPTH);
    localparam int AW      = 32 + RW;
    localparam int HW      = AW - 32;
    localparam int TW      = AW + 18;
    localparam int CW      = TW - 16;
    localparam int SW      = AW + 18;
    localparam int DIM_RST = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam int XW      = gemm_aes_pkg::MUL_W;
    localparam int PW      = gemm_aes_pkg::PROD_W;

    // Configuration registers
    logic        [DW-1:0] r_rows, r_cols, r_inner;
    logic signed [15:0]   r_alpha, r_beta;
    logic        [DW-1:0] w_dim;
    logic                 w_cfg_wr;
    gemm_aes_pkg::t_reg_idx w_idx;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_idx    = gemm_aes_pkg::t_reg_idx'(paddr[4:2]);

    always_comb begin
        if (pwdata[4:0] == 5'd0) begin
            w_dim = DW'(1);
        end else if (7'(pwdata[4:0]) > 7'(MAX_DIM)) begin
            w_dim = DW'(MAX_DIM);
        end else begin
            w_dim = DW'(pwdata[4:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DW'(DIM_RST);
            r_cols  <= DW'(DIM_RST);
            r_inner <= DW'(DIM_RST);
            r_alpha <= 16'sd256;
            r_beta  <= 16'sd0;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                gemm_aes_pkg::REG_ROWS_A:    r_rows  <= w_dim;
                gemm_aes_pkg::REG_COLS_B:    r_cols  <= w_dim;
                gemm_aes_pkg::REG_INNER_LEN: r_inner <= w_dim;
                gemm_aes_pkg::REG_ALPHA:     r_alpha <= pwdata[15:0];
                gemm_aes_pkg::REG_BETA:      r_beta  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            gemm_aes_pkg::REG_ROWS_A:    prdata = 32'(r_rows);
            gemm_aes_pkg::REG_COLS_B:    prdata = 32'(r_cols);
            gemm_aes_pkg::REG_INNER_LEN: prdata = 32'(r_inner);
            gemm_aes_pkg::REG_ALPHA:     prdata = 32'(r_alpha);
            gemm_aes_pkg::REG_BETA:      prdata = 32'(r_beta);
            default:                     prdata = '0;
        endcase
    end

    // Sequencer
    gemm_aes_pkg::t_step  r_pc, n_pc;
    gemm_aes_pkg::t_uword w_uw;
    gemm_aes_pkg::t_action w_act;
    logic [3:0]    r_row, r_col;
    logic [RW-1:0] r_k;
    logic          w_in_acc, w_start, w_ld_ok, w_k_more, w_out_full, w_cond, w_out_fire;
    logic [MW-1:0] w_ld_addr, w_a_addr, w_b_addr, w_c_addr;

    assign w_uw       = gemm_aes_pkg::f_ucode(r_pc);
    assign w_act      = gemm_aes_pkg::t_action'(i_item.action);
    assign i_item.ready = (r_pc == gemm_aes_pkg::ST_IDLE);
    assign w_in_acc   = i_item.valid & i_item.ready;
    assign w_start    = w_in_acc && (w_act == gemm_aes_pkg::ACT_COMPUTE) &&
                        (7'(i_item.row) < 7'(r_rows)) && (7'(i_item.col) < 7'(r_cols));
    assign w_ld_ok    = (7'(i_item.row) < 7'(MAX_DIM)) && (7'(i_item.col) < 7'(MAX_DIM));
    assign w_k_more   = (7'(r_k) + 7'd1) < 7'(r_inner);
    assign w_out_full = o_result.valid & ~o_result.ready;
    assign w_out_fire = (r_pc == gemm_aes_pkg::ST_OUT) && !w_out_full;

    assign w_ld_addr = MW'(int'(i_item.row) * MAX_DIM + int'(i_item.col));
    assign w_a_addr  = MW'(int'(r_row) * MAX_DIM + int'(r_k));
    assign w_b_addr  = MW'(int'(r_k) * MAX_DIM + int'(r_col));
    assign w_c_addr  = MW'(int'(r_row) * MAX_DIM + int'(r_col));

    always_comb begin
        unique case (w_uw.cond)
            gemm_aes_pkg::COND_K_MORE:   w_cond = w_k_more;
            gemm_aes_pkg::COND_OUT_FULL: w_cond = w_out_full;
            default:                     w_cond = 1'b0;
        endcase
        if (r_pc == gemm_aes_pkg::ST_IDLE) begin
            n_pc = w_start ? gemm_aes_pkg::ST_MAC : gemm_aes_pkg::ST_IDLE;
        end else begin
            n_pc = w_cond ? w_uw.jmp : w_uw.nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= gemm_aes_pkg::ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_row <= i_item.row;
            r_col <= i_item.col;
            r_k   <= '0;
        end else if (w_uw.issue && w_k_more) begin
            r_k   <= r_k + RW'(1);
        end
    end

    // Stores
    logic signed [15:0] r_a_mem [DEPTH];
    logic signed [15:0] r_b_mem [DEPTH];
    logic signed [15:0] r_c_mem [DEPTH];
    logic signed [15:0] r_a_q, r_b_q, r_c_q;
    logic signed [15:0] w_c16;

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_ld_ok && w_act == gemm_aes_pkg::ACT_LOAD_A) begin
            r_a_mem[w_ld_addr] <= i_item.value;
        end
        r_a_q <= r_a_mem[w_a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_ld_ok && w_act == gemm_aes_pkg::ACT_LOAD_B) begin
            r_b_mem[w_ld_addr] <= i_item.value;
        end
        r_b_q <= r_b_mem[w_b_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_ld_ok && w_act == gemm_aes_pkg::ACT_LOAD_C) begin
            r_c_mem[w_ld_addr] <= i_item.value;
        end else if (w_out_fire) begin
            r_c_mem[w_c_addr] <= w_c16;
        end
        r_c_q <= r_c_mem[w_c_addr];
    end

    // Shared multiplier
    logic signed [XW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] r_p, w_p_abs;
    logic        [16:0]   w_alpha_abs;
    logic signed [AW-1:0] r_acc;
    logic        [AW-1:0] r_abs;
    logic                 r_v1, r_v2;

    assign w_alpha_abs = r_alpha[15] ? (17'd0 - {r_alpha[15], r_alpha}) : {1'b0, r_alpha};

    always_comb begin
        unique case (w_uw.mul)
            gemm_aes_pkg::MUL_AB: begin
                w_ma = XW'(r_a_q);
                w_mb = XW'(r_b_q);
            end
            gemm_aes_pkg::MUL_AHI: begin
                w_ma = XW'(r_alpha);
                w_mb = {{(XW-HW){r_acc[AW-1]}}, r_acc[AW-1:32]};
            end
            gemm_aes_pkg::MUL_AMID: begin
                w_ma = XW'(r_alpha);
                w_mb = {2'b00, r_acc[31:16]};
            end
            gemm_aes_pkg::MUL_ALO: begin
                w_ma = XW'(r_alpha);
                w_mb = {2'b00, r_acc[15:0]};
            end
            gemm_aes_pkg::MUL_BC: begin
                w_ma = XW'(r_beta);
                w_mb = XW'(r_c_q);
            end
            gemm_aes_pkg::MUL_SHI: begin
                w_ma = {1'b0, w_alpha_abs};
                w_mb = {{(XW-HW){1'b0}}, r_abs[AW-1:32]};
            end
            gemm_aes_pkg::MUL_SMID: begin
                w_ma = {1'b0, w_alpha_abs};
                w_mb = {2'b00, r_abs[31:16]};
            end
            gemm_aes_pkg::MUL_SLO: begin
                w_ma = {1'b0, w_alpha_abs};
                w_mb = {2'b00, r_abs[15:0]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_p_abs = r_p[PW-1] ? -r_p : r_p;

    always_ff @(posedge i_clk) begin
        r_p <= w_ma * w_mb;
    end

    // Valid flags r_v1 and r_v2 follow each issue through the read and product registers to the accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= w_uw.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_acc <= '0;
            r_abs <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + AW'(r_p);
            r_abs <= r_abs + AW'($unsigned(w_p_abs));
        end
    end

    // Scaling accumulators, built up 16 bits at a time from the high chunk down
    logic signed [TW-1:0] r_t;
    logic        [SW-1:0] r_s;

    always_ff @(posedge i_clk) begin
        unique case (w_uw.op)
            gemm_aes_pkg::OP_T_LOAD:  r_t <= TW'(r_p);
            gemm_aes_pkg::OP_T_SHADD: r_t <= (r_t <<< 16) + TW'(r_p);
            gemm_aes_pkg::OP_T_ADD8:  r_t <= r_t + (TW'(r_p) <<< 8);
            gemm_aes_pkg::OP_T_RND:   r_t <= r_t + TW'(32'sd32768);
            gemm_aes_pkg::OP_S_LOAD:  r_s <= SW'($unsigned(r_p));
            gemm_aes_pkg::OP_S_SHADD: r_s <= (r_s << 16) + SW'($unsigned(r_p));
            gemm_aes_pkg::OP_S_RND:   r_s <= r_s + SW'(32768);
            default: ;
        endcase
    end

    // Round, saturate, write back
    logic signed [CW-1:0] w_c_full;
    logic                 w_gt32, w_lt32, w_gt16, w_lt16, w_s_hi, w_sat;
    logic signed [31:0]   w_c32;
    logic        [31:0]   w_sc;

    assign w_c_full = r_t[TW-1:16];
    assign w_gt32 = w_c_full > $signed({{(CW-32){1'b0}}, 32'h7FFF_FFFF});
    assign w_lt32 = w_c_full < $signed({{(CW-32){1'b1}}, 32'h8000_0000});
    assign w_gt16 = w_c_full > $signed({{(CW-16){1'b0}}, 16'h7FFF});
    assign w_lt16 = w_c_full < $signed({{(CW-16){1'b1}}, 16'h8000});
    assign w_s_hi = |r_s[SW-1:48];
    assign w_sat  = w_gt32 | w_lt32 | w_gt16 | w_lt16 | w_s_hi;

    assign w_c32 = w_gt32 ? 32'sh7FFF_FFFF : (w_lt32 ? 32'sh8000_0000 : w_c_full[31:0]);
    assign w_c16 = w_gt16 ? 16'sh7FFF : (w_lt16 ? 16'sh8000 : w_c_full[15:0]);
    assign w_sc  = w_s_hi ? 32'hFFFF_FFFF : r_s[47:16];

    // Output register
    logic                r_out_valid;
    logic        [3:0]   r_out_row, r_out_col;
    logic signed [31:0]  r_out_c;
    logic        [31:0]  r_out_sc;
    logic                r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_out_c   <= w_c32;
            r_out_sc  <= w_sc;
            r_out_sat <= w_sat;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.out_row     = r_out_row;
    assign o_result.out_col     = r_out_col;
    assign o_result.c_value     = r_out_c;
    assign o_result.scale_value = r_out_sc;
    assign o_result.saturated   = r_out_sat;

endmodule

`default_nettype wire

### hdl/gemm_aes_chk.sv
`default_nettype none

module gemm_aes_chk (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic [gemm_aes_pkg::ACTION_W-1:0]   i_in_action,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready
);

    // A waiting result transaction holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A new result only appears after the sequencer was busy
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a compute pass");

    // Loads never occupy the sequencer
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action != gemm_aes_pkg::ACT_COMPUTE)
        |=> i_in_ready)
        else $error("load transaction stalled the input");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind gemm_with_abs_error_scale gemm_aes_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_action (i_item.action),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);

`default_nettype wire
